// ===== hw/rtl/ssfwa_pkg.sv =====
// Shared constants, widths and codes for the sample spike filter with window average.
package ssfwa_pkg;

  localparam int unsigned WINDOW_DEPTH = 64;
  localparam int unsigned PtrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam int unsigned SampleW = 24;
  localparam int unsigned DeltaW  = 23;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SumW    = 31;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned AluW    = 32;
  localparam int unsigned IterW   = $clog2(MagW);

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_MIN_VALUE   = 2'd0,
    REG_MAX_VALUE   = 2'd1,
    REG_MAX_DELTA   = 2'd2,
    REG_SPIKE_CHECK = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_SPIKE    = 2'd2,
    STATUS_AVERAGE  = 2'd3
  } status_e;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_AVERAGE = 1'b1;

  localparam logic signed [SampleW-1:0] MIN_RESET = -24'sd3000;
  localparam logic signed [SampleW-1:0] MAX_RESET = 24'sd6000;
  localparam logic [DeltaW-1:0]         DELTA_RESET = 23'd1500;

endpackage

// ===== hw/rtl/sample_spike_filter_window_average.sv =====
// Top level: sample range and spike filter with a ring window and serial average.
//
// Input channel (in_valid_i / in_stall_o): one beat carries operation_i,
// sample_value_i and sample_invalid_i. operation_i low offers a sample,
// high asks for the truncated average of the window.
// Output channel (out_valid_o / out_stall_i): exactly one result beat per
// input beat, in order, with status_o, average_value_o and entry_count_o.
// A sample passes the range checks, jump check and window update in turn,
// each through the one shared 32 bit adder.
// An average produces one bit of quotient per cycle through the same adder
// over the 30 bit magnitude of the running sum.
// An empty window or an invalid mark goes straight to the output state.
// The next input beat can be taken in the cycle after the result is loaded.
// in_stall_o is high while an item is being worked on; a result waiting in
// the output register does not hold off the next input beat, but the next
// result waits for it to be taken while out_stall_i is high.
// Reset clears the window count, write slot, running sum and last sample
// and loads the register defaults; window contents are left as they are. The user
// writes registers over the APB port only while the block is idle (unchecked).
module sample_spike_filter_window_average (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssfwa_pkg::AddrW-1:0]    paddr,
  input  logic [ssfwa_pkg::DataW-1:0]    pwdata,
  output logic [ssfwa_pkg::DataW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic signed [ssfwa_pkg::SampleW-1:0] sample_value_i,
  input  logic                           sample_invalid_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic signed [ssfwa_pkg::SampleW-1:0] average_value_o,
  output logic [ssfwa_pkg::CountW-1:0]   entry_count_o
);
  import ssfwa_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CMIN = 4'd1;
  localparam logic [3:0] ST_CMAX = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_ABS  = 4'd4;
  localparam logic [3:0] ST_DCMP = 4'd5;
  localparam logic [3:0] ST_SUB  = 4'd6;
  localparam logic [3:0] ST_ADD  = 4'd7;
  localparam logic [3:0] ST_SABS = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_SIGN = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam logic [IterW-1:0]  LastIter = IterW'(MagW - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(WINDOW_DEPTH);
  localparam logic [PtrW-1:0]   LastPtr = PtrW'(WINDOW_DEPTH - 1);

  // configuration
  logic signed [SampleW-1:0] min_q, max_q;
  logic [DeltaW-1:0]         delta_q;
  logic                      spike_en_q;
  logic                      cfg_we;
  reg_idx_e                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= MIN_RESET;
      max_q      <= MAX_RESET;
      delta_q    <= DELTA_RESET;
      spike_en_q <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MIN_VALUE:   min_q      <= pwdata[SampleW-1:0];
        REG_MAX_VALUE:   max_q      <= pwdata[SampleW-1:0];
        REG_MAX_DELTA:   delta_q    <= pwdata[DeltaW-1:0];
        REG_SPIKE_CHECK: spike_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_VALUE:   prdata = DataW'(min_q);
      REG_MAX_VALUE:   prdata = DataW'(max_q);
      REG_MAX_DELTA:   prdata = DataW'(delta_q);
      REG_SPIKE_CHECK: prdata = DataW'(spike_en_q);
      default:         prdata = '0;
    endcase
  end

  // datapath state
  logic [3:0]                state_q, state_d;
  logic                      op_q, op_d;
  logic signed [SampleW-1:0] val_q, val_d;
  logic signed [SampleW-1:0] last_q, last_d;
  logic [PtrW-1:0]           wpos_q, wpos_d;
  logic [CountW-1:0]         count_q, count_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [AluW-1:0]    acc_q, acc_d;
  logic [MagW-1:0]           dvd_q, dvd_d;
  logic [IterW-1:0]          iter_q, iter_d;
  logic                      neg_q, neg_d;
  logic [1:0]                res_status_q, res_status_d;
  logic signed [SampleW-1:0] res_avg_q, res_avg_d;
  logic                      out_valid_q, out_valid_d;
  logic [1:0]                status_q, status_d;
  logic signed [SampleW-1:0] avg_out_q, avg_out_d;
  logic [CountW-1:0]         cnt_out_q, cnt_out_d;

  // shared adder
  logic signed [AluW-1:0] alu_a, alu_b, alu_res;
  logic                   alu_sub;
  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AluW'(alu_sub);

  logic                   in_acc;
  logic                   ram_we, ram_re;
  logic [SampleW-1:0]     ram_rdata;
  logic [AluW-1:0]        rem_sh;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign ram_re     = in_acc;
  assign ram_we     = (state_q == ST_ADD);
  assign rem_sh     = {acc_q[AluW-2:0], dvd_q[MagW-1]};

  ssfwa_ram #(
    .Width(SampleW),
    .Depth(WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wpos_q),
    .wdata_i(val_q),
    .re_i   (ram_re),
    .raddr_i(wpos_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    last_d       = last_q;
    wpos_d       = wpos_q;
    count_d      = count_q;
    sum_d        = sum_q;
    acc_d        = acc_q;
    dvd_d        = dvd_q;
    iter_d       = iter_q;
    neg_d        = neg_q;
    res_status_d = res_status_q;
    res_avg_d    = res_avg_q;
    out_valid_d  = out_valid_q & out_stall_i;
    status_d     = status_q;
    avg_out_d    = avg_out_q;
    cnt_out_d    = cnt_out_q;
    alu_a        = '0;
    alu_b        = '0;
    alu_sub      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d      = operation_i;
          val_d     = sample_value_i;
          res_avg_d = '0;
          if (operation_i == OP_AVERAGE) begin
            res_status_d = STATUS_AVERAGE;
            state_d      = (count_q == '0) ? ST_OUT : ST_SABS;
          end else if (sample_invalid_i) begin
            res_status_d = STATUS_RANGE;
            state_d      = ST_OUT;
          end else begin
            state_d = ST_CMIN;
          end
        end
      end
      ST_CMIN: begin
        alu_a = AluW'(val_q);
        alu_b = AluW'(min_q);
        if (alu_res[AluW-1]) begin
          res_status_d = STATUS_RANGE;
          state_d      = ST_OUT;
        end else begin
          state_d = ST_CMAX;
        end
      end
      ST_CMAX: begin
        alu_a = AluW'(max_q);
        alu_b = AluW'(val_q);
        if (alu_res[AluW-1]) begin
          res_status_d = STATUS_RANGE;
          state_d      = ST_OUT;
        end else if (spike_en_q && count_q != '0) begin
          state_d = ST_DIFF;
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_DIFF: begin
        alu_a   = AluW'(val_q);
        alu_b   = AluW'(last_q);
        acc_d   = alu_res;
        state_d = ST_ABS;
      end
      ST_ABS: begin
        alu_b = acc_q;
        if (acc_q[AluW-1]) begin
          acc_d = alu_res;
        end
        state_d = ST_DCMP;
      end
      ST_DCMP: begin
        alu_a = AluW'(delta_q);
        alu_b = acc_q;
        if (alu_res[AluW-1]) begin
          res_status_d = STATUS_SPIKE;
          state_d      = ST_OUT;
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        alu_a = AluW'(sum_q);
        alu_b = AluW'($signed(ram_rdata));
        if (count_q == FullCount) begin
          sum_d = alu_res[SumW-1:0];
        end else begin
          count_d = count_q + 1'b1;
        end
        state_d = ST_ADD;
      end
      ST_ADD: begin
        alu_a        = AluW'(sum_q);
        alu_b        = AluW'(val_q);
        alu_sub      = 1'b0;
        sum_d        = alu_res[SumW-1:0];
        last_d       = val_q;
        wpos_d       = (wpos_q == LastPtr) ? '0 : wpos_q + 1'b1;
        res_status_d = STATUS_ACCEPTED;
        state_d      = ST_OUT;
      end
      ST_SABS: begin
        alu_b   = AluW'(sum_q);
        neg_d   = sum_q[SumW-1];
        dvd_d   = sum_q[SumW-1] ? alu_res[MagW-1:0] : sum_q[MagW-1:0];
        acc_d   = '0;
        iter_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        alu_a = rem_sh;
        alu_b = AluW'(count_q);
        if (alu_res[AluW-1]) begin
          acc_d = rem_sh;
          dvd_d = {dvd_q[MagW-2:0], 1'b0};
        end else begin
          acc_d = alu_res;
          dvd_d = {dvd_q[MagW-2:0], 1'b1};
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == LastIter) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        alu_b     = AluW'(dvd_q);
        res_avg_d = neg_q ? alu_res[SampleW-1:0] : dvd_q[SampleW-1:0];
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          avg_out_d   = res_avg_q;
          cnt_out_d   = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wpos_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    acc_q        <= acc_d;
    dvd_q        <= dvd_d;
    iter_q       <= iter_d;
    neg_q        <= neg_d;
    res_status_q <= res_status_d;
    res_avg_q    <= res_avg_d;
    status_q     <= status_d;
    avg_out_q    <= avg_out_d;
    cnt_out_q    <= cnt_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign average_value_o = avg_out_q;
  assign entry_count_o   = cnt_out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("window count above depth");

  a_add_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |=> (count_q != '0) && (state_q == ST_OUT))
    else $error("window update did not leave a held sample");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && iter_q == LastIter) |=> (state_q == ST_SIGN))
    else $error("division did not finish after the last quotient bit");

  a_avg_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SABS) |-> (op_q == OP_AVERAGE) && (count_q != '0))
    else $error("division started without an average request on a filled window");
`endif

endmodule

// ===== hw/rtl/ssfwa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module ssfwa_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/sample_spike_filter_window_average_tb.sv =====
// Testbench for the sample spike filter with window average: predicted results, APB setup.
module sample_spike_filter_window_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfwa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned PHASE_ITEMS  = 128;
  localparam int unsigned NUM_SETTINGS = 8;
  localparam longint      S24_MIN      = -8388608;
  localparam longint      S24_MAX      = 8388607;

  typedef struct {
    status_e                    status;
    logic signed [SampleW-1:0]  avg;
    logic [CountW-1:0]          count;
  } verdict_t;

  typedef struct {
    int lo;
    int hi;
    int jump;
    bit on;
  } setting_t;

  class filter_checker;
    logic signed [SampleW-1:0] lo_limit;
    logic signed [SampleW-1:0] hi_limit;
    logic [DeltaW-1:0]         jump_limit;
    logic                      jump_check_on;
    logic signed [SampleW-1:0] window_q [WINDOW_DEPTH];
    int unsigned               slot;
    int unsigned               held;
    longint                    sum;
    logic signed [SampleW-1:0] last_kept;
    verdict_t                  due_q[$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               tally[4];

    function new();
      lo_limit      = MIN_RESET;
      hi_limit      = MAX_RESET;
      jump_limit    = DELTA_RESET;
      jump_check_on = 1'b1;
      slot          = 0;
      held          = 0;
      sum           = 0;
      last_kept     = '0;
      errors        = 0;
      checked       = 0;
      tally         = '{default: 0};
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] val);
      case (idx)
        REG_MIN_VALUE:   lo_limit = val[SampleW-1:0];
        REG_MAX_VALUE:   hi_limit = val[SampleW-1:0];
        REG_MAX_DELTA:   jump_limit = val[DeltaW-1:0];
        REG_SPIKE_CHECK: jump_check_on = val[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic op, logic signed [SampleW-1:0] v, logic inv);
      verdict_t want;
      longint   d;
      want.avg = '0;
      if (op == OP_AVERAGE) begin
        want.status = STATUS_AVERAGE;
        if (held != 0) want.avg = SampleW'(sum / longint'(held));
      end else if (inv || v < lo_limit || v > hi_limit) begin
        want.status = STATUS_RANGE;
      end else begin
        d = longint'(v) - longint'(last_kept);
        if (d < 0) d = -d;
        if (jump_check_on && held != 0 && d > longint'(jump_limit)) begin
          want.status = STATUS_SPIKE;
        end else begin
          if (held == WINDOW_DEPTH) sum -= longint'(window_q[slot]);
          else held++;
          window_q[slot] = v;
          sum += longint'(v);
          last_kept = v;
          slot = (slot + 1) % WINDOW_DEPTH;
          want.status = STATUS_ACCEPTED;
        end
      end
      want.count = CountW'(held);
      tally[int'(want.status)]++;
      due_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_verdict(logic [1:0] st, logic signed [SampleW-1:0] avg,
                       logic [CountW-1:0] cnt);
      verdict_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result beat with nothing pending, status %0d", st));
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (st !== want.status)
        report($sformatf("status %0d, predicted %0d", st, want.status));
      if (avg !== want.avg)
        report($sformatf("average %0d, predicted %0d", avg, want.avg));
      if (cnt !== want.count)
        report($sformatf("entry count %0d, predicted %0d", cnt, want.count));
    endtask
  endclass

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [AddrW-1:0]          paddr = '0;
  logic [DataW-1:0]          pwdata = '0;
  logic [DataW-1:0]          prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      operation_i = OP_SAMPLE;
  logic signed [SampleW-1:0] sample_value_i = '0;
  logic                      sample_invalid_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                status_o;
  logic signed [SampleW-1:0] average_value_o;
  logic [CountW-1:0]         entry_count_o;

  filter_checker chk = new();
  int unsigned   tx_idle_pct = 25;
  int unsigned   rx_idle_pct = 60;
  bit            hold_off_req = 1'b0;
  int unsigned   cycle_count = 0;
  int unsigned   beats_sent = 0;

  setting_t plan [NUM_SETTINGS] = '{
    '{-8388608, 8388607, 8388607, 1'b1},
    '{-8388608, 8388607, 0,       1'b1},
    '{8388607,  8388607, 5,       1'b0},
    '{-8388608, -8388608, 0,      1'b0},
    '{500,      -500,    100,     1'b1},
    '{-1000,    1000,    300,     1'b0},
    '{-3000,    6000,    1500,    1'b1},
    '{-200000,  300000,  40000,   1'b0}
  };

  sample_spike_filter_window_average i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .sample_value_i   (sample_value_i),
    .sample_invalid_i (sample_invalid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .average_value_o  (average_value_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, chk.due_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // output back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      chk.check_verdict(status_o, average_value_o, entry_count_o);
  end

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] val);
    logic [DataW-1:0] rd;
    logic [DataW-1:0] mask;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    chk.set_reg(idx, val);
    case (idx)
      REG_MIN_VALUE, REG_MAX_VALUE: mask = 32'h00FF_FFFF;
      REG_MAX_DELTA:                mask = 32'h007F_FFFF;
      default:                      mask = 32'h0000_0001;
    endcase
    if ((rd & mask) !== (val & mask))
      chk.report($sformatf("register %s read back %0h, written %0h", idx.name(), rd, val));
  endtask

  task automatic send_beat(logic op, logic signed [SampleW-1:0] v, logic inv);
    int unsigned gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    sample_value_i   <= v;
    sample_invalid_i <= inv;
    do @(posedge clk_i); while (in_stall_o);
    chk.note_item(op, v, inv);
    beats_sent++;
  endtask

  task automatic wait_drained();
    while (chk.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(REG_MIN_VALUE, DataW'(s.lo));
    write_reg(REG_MAX_VALUE, DataW'(s.hi));
    write_reg(REG_MAX_DELTA, DataW'(s.jump));
    write_reg(REG_SPIKE_CHECK, DataW'(s.on));
  endtask

  function automatic logic signed [SampleW-1:0] clamp24(longint x);
    if (x < S24_MIN) return SampleW'(S24_MIN);
    if (x > S24_MAX) return SampleW'(S24_MAX);
    return SampleW'(x);
  endfunction

  function automatic void next_sample(output logic op, output logic signed [SampleW-1:0] v,
                                      output logic inv);
    int unsigned r = $urandom_range(99);
    longint      lo = longint'(chk.lo_limit);
    longint      hi = longint'(chk.hi_limit);
    longint      last = longint'(chk.last_kept);
    longint      jump = longint'(chk.jump_limit);
    longint      picks[8];
    op  = OP_SAMPLE;
    inv = 1'b0;
    v   = SampleW'($urandom);
    if (r < 10) begin
      op  = OP_AVERAGE;
      inv = $urandom_range(1);
    end else if (r < 15) begin
      inv = 1'b1;
    end else if (r < 25) begin
      // raw value already drawn
    end else if (r < 33) begin
      picks = '{lo, hi, lo - 1, hi + 1, last - jump - 1, last + jump + 1,
                last - jump, last + jump};
      v = clamp24(picks[$urandom_range(7)]);
    end else begin
      if (chk.jump_check_on && chk.held != 0) begin
        if (last - jump > lo) lo = last - jump;
        if (last + jump < hi) hi = last + jump;
      end
      if (lo <= hi) v = SampleW'(lo + longint'($urandom_range(int'(hi - lo))));
    end
  endfunction

  initial begin
    logic                      op;
    logic signed [SampleW-1:0] v;
    logic                      inv;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register defaults after reset
    send_beat(OP_AVERAGE, 24'sd0, 1'b0);
    send_beat(OP_SAMPLE, 24'sd100, 1'b1);
    send_beat(OP_SAMPLE, -24'sd3000, 1'b0);
    send_beat(OP_SAMPLE, -24'sd3001, 1'b0);
    send_beat(OP_SAMPLE, 24'sd6001, 1'b0);
    send_beat(OP_SAMPLE, -24'sd1500, 1'b0);
    send_beat(OP_SAMPLE, 24'sd1, 1'b0);
    send_beat(OP_AVERAGE, -24'sd1, 1'b1);
    send_beat(OP_SAMPLE, 24'sd0, 1'b0);
    send_beat(OP_SAMPLE, -24'sd1, 1'b0);
    send_beat(OP_AVERAGE, 24'sh7FFFFF, 1'b0);
    send_beat(OP_SAMPLE, 24'sh7FFFFF, 1'b0);
    send_beat(OP_SAMPLE, -24'sh800000, 1'b0);
    send_beat(OP_SAMPLE, 24'sd6000, 1'b0);
    send_beat(OP_SAMPLE, 24'sd6000, 1'b1);
    in_valid_i <= 1'b0;
    wait_drained();

    apply_setting('{-8388608, 8388607, 8388607, 1'b1});
    send_beat(OP_SAMPLE, 24'sh7FFFFF, 1'b0);
    send_beat(OP_SAMPLE, 24'sh7FFFFE, 1'b0);
    send_beat(OP_SAMPLE, -24'sd1, 1'b0);
    send_beat(OP_SAMPLE, -24'sh800000, 1'b0);
    send_beat(OP_AVERAGE, -24'sh800000, 1'b1);
    in_valid_i <= 1'b0;
    wait_drained();
    write_reg(REG_SPIKE_CHECK, 32'd0);
    send_beat(OP_SAMPLE, -24'sh800000, 1'b0);
    send_beat(OP_SAMPLE, 24'sh7FFFFF, 1'b0);
    send_beat(OP_AVERAGE, 24'sd0, 1'b0);
    in_valid_i <= 1'b0;
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p < 3) begin
        tx_idle_pct = 25;
        rx_idle_pct = 60;
      end else if (p < 6) begin
        tx_idle_pct = 60;
        rx_idle_pct = 25;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      apply_setting(plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 30) hold_off_req = 1'b1;
        next_sample(op, v, inv);
        send_beat(op, v, inv);
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    $display("Drove %0d input beats over %0d register settings with varied idling and a %0d-cycle output hold-off.",
             beats_sent, NUM_SETTINGS + 2, HOLD_CYCLES);
    $display("Checked %0d results: %0d kept, %0d out of range or invalid, %0d jumps, %0d averages; %0d mismatches.",
             chk.checked, chk.tally[STATUS_ACCEPTED], chk.tally[STATUS_RANGE],
             chk.tally[STATUS_SPIKE], chk.tally[STATUS_AVERAGE], chk.errors);
    if (chk.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
